/* src/xad_pkg.sv */
`default_nettype none
package xad_pkg;

  localparam int CHANNELS_DEFAULT = 8;

  localparam logic [7:0] LITERAL_MARK     = 8'hEE;
  localparam logic [5:0] LIT_BYTES        = 6'd61;
  localparam logic [5:0] ADPCM_BYTES      = 6'd15;
  localparam logic [4:0] FRAME_SAMPLES    = 5'd28;
  localparam logic [5:0] POS_NEWEST       = 6'd2;
  localparam logic [5:0] POS_OLDER        = 6'd4;
  localparam logic [5:0] LIT_FIRST_SAMPLE = 6'd6;
  localparam logic [4:0] SCALE_BASE       = 5'd20;
  localparam logic signed [15:0] PCM_MAX  = 16'sh7FFF;
  localparam logic signed [15:0] PCM_MIN  = 16'sh8000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_MUL,
    ST_SUM,
    ST_WB
  } state_t;

  // per-channel state word held in the RAM
  typedef struct packed {
    logic [15:0] newest;
    logic [15:0] older;
    logic [5:0]  pos;
    logic [7:0]  hdr;
    logic [4:0]  lim;
    logic [7:0]  pend;
  } chan_state_t;

  typedef struct packed {
    logic [3:0]  nibble;
    logic [7:0]  hdr;
    logic [15:0] newest;
    logic [15:0] older;
  } pred_req_t;

  function automatic logic signed [9:0] coef_one(input logic [1:0] sel);
    logic signed [9:0] c;
    case (sel)
      2'd0:    c = 10'sd0;
      2'd1:    c = 10'sd240;
      2'd2:    c = 10'sd460;
      default: c = 10'sd392;
    endcase
    return c;
  endfunction

  function automatic logic signed [9:0] coef_two(input logic [1:0] sel);
    logic signed [9:0] c;
    case (sel)
      2'd0:    c = 10'sd0;
      2'd1:    c = 10'sd0;
      2'd2:    c = -10'sd208;
      default: c = -10'sd220;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

/* src/xad_byte_if.sv */
`default_nettype none
interface xad_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [2:0] channel;
  logic [4:0] sample_limit;

  modport source(output valid, data_byte, channel, sample_limit, input ready);
  modport sink(input valid, data_byte, channel, sample_limit, output ready);
endinterface
`default_nettype wire

/* src/xad_sample_if.sv */
`default_nettype none
interface xad_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic [2:0]         sample_channel;
  logic               frame_done;
  logic               last_of_run;

  modport source(output valid, sample, sample_channel, frame_done, last_of_run,
                 input ready);
  modport sink(input valid, sample, sample_channel, frame_done, last_of_run,
               output ready);
endinterface
`default_nettype wire

/* src/xad_ram.sv */
`default_nettype none
module xad_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* src/xad_predictor.sv */
`default_nettype none
module xad_predictor
  import xad_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               mul_en,
  input  wire pred_req_t          req,
  output logic signed [15:0]      y
);

  logic signed [25:0] prod_one;
  logic signed [25:0] prod_two;
  logic signed [27:0] res_term;
  logic signed [27:0] nib_ext;
  logic [4:0]         scale;
  logic signed [27:0] acc;
  logic signed [19:0] quot;

  assign nib_ext = {{24{req.nibble[3]}}, req.nibble};
  assign scale   = SCALE_BASE - {1'b0, req.hdr[3:0]};

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_one <= 26'(coef_one(req.hdr[5:4])) * 26'($signed(req.newest));
      prod_two <= 26'(coef_two(req.hdr[5:4])) * 26'($signed(req.older));
      res_term <= nib_ext <<< scale;
    end
  end

  assign acc  = res_term + {{2{prod_one[25]}}, prod_one} + {{2{prod_two[25]}}, prod_two};
  // arithmetic shift gives the floor of acc / 256
  assign quot = acc[27:8];

  always_comb begin
    if (quot[19:15] != {5{quot[15]}}) begin
      y = quot[19] ? PCM_MIN : PCM_MAX;
    end else begin
      y = quot[15:0];
    end
  end

endmodule
`default_nettype wire

/* src/xa_adpcm_frame_decoder.sv */
// Interleaved multi-channel ADPCM frame decoder.
// bytes: one frame-stream byte per transaction, tagged with its channel and,
//   on a frame's header byte, the number of samples to emit (saturated at 28).
//   Bytes for a channel at or above CHANNELS are taken and dropped.
// samples: decoded 16-bit PCM, with channel, end-of-frame flag and a flag on
//   the last sample caused by the byte. A byte yields zero, one or two samples.
// Per-channel state lives in one RAM word, read in the cycle after the byte is
// taken and written back before the next byte is taken.
// Steps per byte: accept, read, execute and write-back for a header or literal
// byte; an ADPCM residual byte adds a multiply step per nibble and a sum step
// per emitted nibble. A literal sample is registered from the execute step, an
// ADPCM sample from the sum step that follows its multiply step.
// The output register holds a sample until taken; a stalled receiver holds
// the decoder in its emit step and bytes stop being accepted.
// Reset (synchronous, rst high) clears all channel states through per-entry
// valid bits: every channel awaits a frame header with zero histories.
`default_nettype none
module xa_adpcm_frame_decoder
  import xad_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEFAULT
) (
  input  wire logic   clk,
  input  wire logic   rst,
  xad_byte_if.sink    bytes,
  xad_sample_if.source samples
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SW = $bits(chan_state_t);

  state_t        state, state_next;
  chan_state_t   work, work_next;
  chan_state_t   ram_rdata;
  logic          k, k_next;
  logic [7:0]    cur_byte;
  logic [2:0]    cur_ch;
  logic [4:0]    cur_lim;
  logic [AW-1:0] cur_addr;
  logic [CHANNELS-1:0] chan_valid;

  logic          accept, in_range;
  logic          ram_re, ram_we, mul_en;
  logic          out_free;
  logic          emit;
  logic signed [15:0] emit_sample;
  logic          emit_done, emit_last;

  logic [15:0]   word;
  logic [5:0]    lit_idx;
  logic [5:0]    pos_inc;
  logic [5:0]    idx;
  logic [5:0]    idx_inc;
  logic [5:0]    lim_ext;
  pred_req_t     req;
  logic signed [15:0] pred_y;

  assign accept   = bytes.valid && bytes.ready;
  assign in_range = (32'(bytes.channel) < CHANNELS);
  assign cur_addr = AW'(cur_ch);
  assign out_free = !samples.valid || samples.ready;

  assign word    = {work.pend, cur_byte};
  assign lit_idx = (work.pos - LIT_FIRST_SAMPLE) >> 1;
  assign pos_inc = work.pos + 6'd1;
  assign lim_ext = {1'b0, work.lim};
  assign idx     = {work.pos[4:0] - 5'd1, k};
  assign idx_inc = idx + 6'd1;

  assign req.nibble = k ? cur_byte[3:0] : cur_byte[7:4];
  assign req.hdr    = work.hdr;
  assign req.newest = work.newest;
  assign req.older  = work.older;

  xad_ram #(.WIDTH(SW), .DEPTH(CHANNELS)) u_state_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (cur_addr),
    .wr_data (work),
    .rd_en   (ram_re),
    .rd_addr (AW'(bytes.channel)),
    .rd_data (ram_rdata)
  );

  xad_predictor u_predictor (
    .clk    (clk),
    .mul_en (mul_en),
    .req    (req),
    .y      (pred_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      chan_valid <= '0;
      k          <= 1'b0;
    end else begin
      state <= state_next;
      k     <= k_next;
      if (ram_we) begin
        chan_valid[cur_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    work <= work_next;
    if (accept) begin
      cur_byte <= bytes.data_byte;
      cur_ch   <= bytes.channel;
      cur_lim  <= bytes.sample_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      samples.valid <= 1'b0;
    end else if (emit) begin
      samples.valid <= 1'b1;
    end else if (samples.ready) begin
      samples.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      samples.sample         <= emit_sample;
      samples.sample_channel <= cur_ch;
      samples.frame_done     <= emit_done;
      samples.last_of_run    <= emit_last;
    end
  end

  always_comb begin
    state_next  = state;
    work_next   = work;
    k_next      = k;
    bytes.ready = 1'b0;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    mul_en      = 1'b0;
    emit        = 1'b0;
    emit_sample = '0;
    emit_done   = 1'b0;
    emit_last   = 1'b0;

    unique case (state)
      ST_IDLE: begin
        bytes.ready = 1'b1;
        if (bytes.valid && in_range) begin
          ram_re     = 1'b1;
          state_next = ST_READ;
        end
      end

      ST_READ: begin
        // an entry never written back reads as the reset state
        work_next  = chan_valid[cur_addr] ? ram_rdata : '0;
        state_next = ST_EXEC;
      end

      ST_EXEC: begin
        if (work.pos == '0) begin
          work_next.hdr = cur_byte;
          work_next.lim = (cur_lim > FRAME_SAMPLES) ? FRAME_SAMPLES : cur_lim;
          work_next.pos = 6'd1;
          state_next    = ST_WB;
        end else if (work.hdr == LITERAL_MARK) begin
          if (work.pos[0]) begin
            work_next.pend = cur_byte;
            work_next.pos  = (pos_inc >= LIT_BYTES) ? '0 : pos_inc;
            state_next     = ST_WB;
          end else if (work.pos == POS_NEWEST) begin
            work_next.newest = word;
            work_next.pos    = pos_inc;
            state_next       = ST_WB;
          end else if (work.pos == POS_OLDER) begin
            work_next.older = word;
            work_next.pos   = pos_inc;
            state_next      = ST_WB;
          end else if (lit_idx < lim_ext) begin
            // wait here while the output register is still occupied
            if (out_free) begin
              emit             = 1'b1;
              emit_sample      = word;
              emit_done        = (lit_idx + 6'd1 == lim_ext);
              emit_last        = 1'b1;
              work_next.older  = work.newest;
              work_next.newest = word;
              work_next.pos    = (pos_inc >= LIT_BYTES) ? '0 : pos_inc;
              state_next       = ST_WB;
            end
          end else begin
            work_next.pos = (pos_inc >= LIT_BYTES) ? '0 : pos_inc;
            state_next    = ST_WB;
          end
        end else begin
          k_next     = 1'b0;
          state_next = ST_MUL;
        end
      end

      ST_MUL: begin
        if (idx >= lim_ext) begin
          if (!k) begin
            k_next = 1'b1;
          end else begin
            work_next.pos = (pos_inc >= ADPCM_BYTES) ? '0 : pos_inc;
            state_next    = ST_WB;
          end
        end else begin
          mul_en     = 1'b1;
          state_next = ST_SUM;
        end
      end

      ST_SUM: begin
        if (out_free) begin
          emit             = 1'b1;
          emit_sample      = pred_y;
          emit_done        = (idx_inc == lim_ext);
          emit_last        = k || (idx_inc >= lim_ext);
          work_next.older  = work.newest;
          work_next.newest = pred_y;
          if (!k) begin
            k_next     = 1'b1;
            state_next = ST_MUL;
          end else begin
            work_next.pos = (pos_inc >= ADPCM_BYTES) ? '0 : pos_inc;
            state_next    = ST_WB;
          end
        end
      end

      ST_WB: begin
        ram_we     = 1'b1;
        state_next = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_read_follows_accept: assert property (@(posedge clk) disable iff (rst)
    (accept && in_range) |=> (state == ST_READ))
    else $error("state read did not follow an accepted byte");

  a_dropped_channel: assert property (@(posedge clk) disable iff (rst)
    (accept && !in_range) |=> (state == ST_IDLE))
    else $error("out-of-range channel started a state access");

  a_wb_pos_range: assert property (@(posedge clk) disable iff (rst)
    (ram_we && work.hdr != LITERAL_MARK) |-> (work.pos < ADPCM_BYTES))
    else $error("ADPCM frame position out of range at write-back");

  a_lit_emit_pos: assert property (@(posedge clk) disable iff (rst)
    (emit && state == ST_EXEC) |-> (!work.pos[0] && work.pos >= LIT_FIRST_SAMPLE))
    else $error("literal sample emitted at a non-sample position");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> out_free)
    else $error("sample emitted into an occupied output register");

endmodule
`default_nettype wire

/* tb/sv/xad_decode_checker.sv */
`timescale 1ns / 1ps
module xad_decode_checker
  import xad_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEFAULT
) (
  input  logic  clk,
  input  logic  rst,
  xad_byte_if   byte_mon,
  xad_sample_if sample_mon,
  output int    fail_count,
  output int    outstanding
);

  localparam int ACC_FRAC    = 8;
  localparam int C1_SEL1     = 240;
  localparam int C1_SEL2     = 460;
  localparam int C2_SEL2     = -208;
  localparam int C1_SEL3     = 392;
  localparam int C2_SEL3     = -220;

  typedef struct packed {
    logic signed [15:0] sample;
    logic [2:0]         channel;
    logic               frame_done;
    logic               last_of_run;
  } pcm_result_t;

  logic [15:0] hist_new  [CHANNELS];
  logic [15:0] hist_old  [CHANNELS];
  logic [5:0]  frame_pos [CHANNELS];
  logic [7:0]  frame_hdr [CHANNELS];
  logic [4:0]  frame_lim [CHANNELS];
  logic [7:0]  hi_byte   [CHANNELS];

  pcm_result_t pending_samples[$];
  int          mismatches = 0;

  // two-tap predictor: floor((r << scale + c1*h1 + c2*h2) / 256), clamped
  function automatic logic [15:0] predict_nibble(input logic [3:0] nib,
                                                 input logic [7:0] hdr,
                                                 input logic [15:0] h1,
                                                 input logic [15:0] h2);
    int c1, c2, shift, acc, y;
    case (hdr[5:4])
      2'd0:    begin c1 = 0;       c2 = 0;       end
      2'd1:    begin c1 = C1_SEL1; c2 = 0;       end
      2'd2:    begin c1 = C1_SEL2; c2 = C2_SEL2; end
      default: begin c1 = C1_SEL3; c2 = C2_SEL3; end
    endcase
    shift = int'(SCALE_BASE) - int'(hdr[3:0]);
    acc = int'($signed(nib)) * (32'sd1 <<< shift)
        + c1 * int'($signed(h1)) + c2 * int'($signed(h2));
    y = acc >>> ACC_FRAC;
    if (y > int'(PCM_MAX)) y = int'(PCM_MAX);
    if (y < int'(PCM_MIN)) y = int'(PCM_MIN);
    return y[15:0];
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic [2:0] ch,
                             input logic [4:0] lim_in);
    pcm_result_t res [2];
    int          n, idx, k;
    logic [5:0]  p;
    logic [4:0]  lim;
    logic [15:0] word;
    logic [3:0]  nib;
    n = 0;
    if (int'(ch) >= CHANNELS) return;
    p = frame_pos[ch];
    if (p == 6'd0) begin
      frame_hdr[ch] = b;
      frame_lim[ch] = (lim_in > FRAME_SAMPLES) ? FRAME_SAMPLES : lim_in;
      frame_pos[ch] = 6'd1;
      return;
    end
    lim = frame_lim[ch];
    if (frame_hdr[ch] == LITERAL_MARK) begin
      if (p[0]) begin
        hi_byte[ch] = b;
      end else begin
        word = {hi_byte[ch], b};
        if (p == POS_NEWEST) begin
          hist_new[ch] = word;
        end else if (p == POS_OLDER) begin
          hist_old[ch] = word;
        end else begin
          idx = (int'(p) - int'(LIT_FIRST_SAMPLE)) / 2;
          if (idx < int'(lim)) begin
            res[n].sample      = word;
            res[n].channel     = ch;
            res[n].frame_done  = (idx + 1 == int'(lim));
            res[n].last_of_run = 1'b0;
            n++;
            hist_old[ch] = hist_new[ch];
            hist_new[ch] = word;
          end
        end
      end
      p = p + 6'd1;
      if (p >= LIT_BYTES) p = 6'd0;
    end else begin
      for (k = 0; k < 2; k++) begin
        idx = 2 * (int'(p) - 1) + k;
        nib = (k == 0) ? b[7:4] : b[3:0];
        if (idx < int'(lim)) begin
          word = predict_nibble(nib, frame_hdr[ch], hist_new[ch], hist_old[ch]);
          res[n].sample      = word;
          res[n].channel     = ch;
          res[n].frame_done  = (idx + 1 == int'(lim));
          res[n].last_of_run = 1'b0;
          n++;
          hist_old[ch] = hist_new[ch];
          hist_new[ch] = word;
        end
      end
      p = p + 6'd1;
      if (p >= ADPCM_BYTES) p = 6'd0;
    end
    frame_pos[ch] = p;
    if (n > 0) res[n-1].last_of_run = 1'b1;
    for (k = 0; k < n; k++) pending_samples.push_back(res[k]);
  endtask

  task automatic report_field(input string field, input int want, input int got);
    mismatches++;
    $error("%s: expected %0d, actual %0d", field, want, got);
  endtask

  task automatic check_sample();
    pcm_result_t want;
    if (pending_samples.size() == 0) begin
      mismatches++;
      $error("sample transaction with nothing pending: sample %0d channel %0d",
             sample_mon.sample, sample_mon.sample_channel);
      return;
    end
    want = pending_samples.pop_front();
    if (sample_mon.sample !== want.sample)
      report_field("sample", int'(want.sample), int'(sample_mon.sample));
    if (sample_mon.sample_channel !== want.channel)
      report_field("sample_channel", int'(want.channel), int'(sample_mon.sample_channel));
    if (sample_mon.frame_done !== want.frame_done)
      report_field("frame_done", int'(want.frame_done), int'(sample_mon.frame_done));
    if (sample_mon.last_of_run !== want.last_of_run)
      report_field("last_of_run", int'(want.last_of_run), int'(sample_mon.last_of_run));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        hist_new[c]  = '0;
        hist_old[c]  = '0;
        frame_pos[c] = '0;
        frame_hdr[c] = '0;
        frame_lim[c] = '0;
        hi_byte[c]   = '0;
      end
      pending_samples.delete();
    end else begin
      if (sample_mon.valid && sample_mon.ready) check_sample();
      if (byte_mon.valid && byte_mon.ready)
        decode_byte(byte_mon.data_byte, byte_mon.channel, byte_mon.sample_limit);
    end
    fail_count  <= mismatches;
    outstanding <= pending_samples.size();
  end

endmodule

/* tb/sv/xa_adpcm_frame_decoder_test.sv */
`timescale 1ns / 1ps
module xa_adpcm_frame_decoder_test;
  import xad_pkg::*;

  localparam int NUM_CHANNELS = CHANNELS_DEFAULT;
  localparam int RANDOM_BYTES = 1600;
  localparam int QUIET_BYTES  = 200;
  localparam int DRAIN_CYCLES = 32;
  localparam int CYCLE_LIMIT  = 600000;

  logic clk = 1'b0;
  logic rst;
  int   cycle_count = 0;
  int   fail_count;
  int   outstanding;
  bit   tx_choppy = 1'b1;
  bit   rx_choppy = 1'b1;
  bit   quiet = 1'b0;
  int   stall_left = 0;
  int   stream_pos [NUM_CHANNELS];
  int   stream_len [NUM_CHANNELS];

  xad_byte_if   bytes_if();
  xad_sample_if samples_if();

  xa_adpcm_frame_decoder #(
    .CHANNELS(NUM_CHANNELS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .bytes(bytes_if),
    .samples(samples_if)
  );

  xad_decode_checker #(
    .CHANNELS(NUM_CHANNELS)
  ) checker_i (
    .clk(clk),
    .rst(rst),
    .byte_mon(bytes_if),
    .sample_mon(samples_if),
    .fail_count(fail_count),
    .outstanding(outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // sample receiver: random stall bursts while choppy
  always @(posedge clk) begin
    if ($urandom_range(0, 299) == 0) rx_choppy <= !rx_choppy;
    if (stall_left > 0) begin
      samples_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rx_choppy && !quiet && $urandom_range(0, 5) == 0) begin
      samples_if.ready <= 1'b0;
      stall_left <= $urandom_range(0, 14);
    end else begin
      samples_if.ready <= 1'b1;
    end
  end

  function automatic logic [3:0] extreme_nibble();
    case ($urandom_range(0, 3))
      0:       return 4'h0;
      1:       return 4'h7;
      2:       return 4'h8;
      default: return 4'hF;
    endcase
  endfunction

  // one byte transaction; also tracks where each channel is in its frame
  task automatic send_byte(input logic [7:0] b, input logic [2:0] ch,
                           input logic [4:0] lim);
    int gap;
    if (tx_choppy && !quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 15);
      bytes_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    bytes_if.valid        <= 1'b1;
    bytes_if.data_byte    <= b;
    bytes_if.channel      <= ch;
    bytes_if.sample_limit <= lim;
    do @(posedge clk); while (!bytes_if.ready);
    if (stream_pos[ch] == 0) begin
      stream_len[ch] = (b == LITERAL_MARK) ? int'(LIT_BYTES) : int'(ADPCM_BYTES);
      stream_pos[ch] = 1;
    end else begin
      stream_pos[ch]++;
      if (stream_pos[ch] == stream_len[ch]) stream_pos[ch] = 0;
    end
  endtask

  task automatic wait_for_drain();
    bytes_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    logic [7:0] b;
    logic [2:0] ch;
    logic [4:0] lim;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      stream_pos[c] = 0;
      stream_len[c] = 0;
    end
    rst                   <= 1'b1;
    bytes_if.valid        <= 1'b0;
    bytes_if.data_byte    <= '0;
    bytes_if.channel      <= '0;
    bytes_if.sample_limit <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // smallest shift, limit saturated, residual extremes
    send_byte(8'h3F, 3'd0, 5'd31);
    send_byte(8'h77, 3'd0, 5'd0);
    send_byte(8'h88, 3'd0, 5'd31);
    send_byte(8'h80, 3'd0, 5'd0);
    send_byte(8'h08, 3'd0, 5'd31);
    // largest shift: clamps at both rails
    send_byte(8'h20, 3'd1, FRAME_SAMPLES);
    send_byte(8'h77, 3'd1, 5'd0);
    send_byte(8'h77, 3'd1, 5'd0);
    send_byte(8'h88, 3'd1, 5'd0);
    send_byte(8'h88, 3'd1, 5'd0);
    // zero limit: bytes consumed silently
    send_byte(8'h10, 3'd2, 5'd0);
    send_byte(8'hFF, 3'd2, 5'd31);
    send_byte(8'h00, 3'd2, 5'd31);
    // literal: history words, two samples, then silent bytes past the limit
    send_byte(LITERAL_MARK, 3'd3, 5'd2);
    send_byte(8'h7F, 3'd3, 5'd0);
    send_byte(8'hFF, 3'd3, 5'd0);
    send_byte(8'h80, 3'd3, 5'd0);
    send_byte(8'h00, 3'd3, 5'd0);
    send_byte(8'h80, 3'd3, 5'd0);
    send_byte(8'h00, 3'd3, 5'd0);
    send_byte(8'h7F, 3'd3, 5'd0);
    send_byte(8'hFF, 3'd3, 5'd0);
    send_byte(8'h12, 3'd3, 5'd0);
    send_byte(8'h34, 3'd3, 5'd0);
    // limit of one: second nibble of the byte is dropped
    send_byte(8'h05, 3'd4, 5'd1);
    send_byte(8'hF7, 3'd4, 5'd1);
    wait_for_drain();

    for (int i = 0; i < RANDOM_BYTES; i++) begin
      if (i == RANDOM_BYTES / 2) wait_for_drain();
      if (i == RANDOM_BYTES - QUIET_BYTES) quiet = 1'b1;
      if ($urandom_range(0, 99) == 0) tx_choppy = !tx_choppy;
      ch = 3'($urandom_range(0, NUM_CHANNELS - 1));
      if (stream_pos[ch] == 0) begin
        b = ($urandom_range(0, 3) == 0) ? LITERAL_MARK : 8'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
          0:       lim = 5'd0;
          1:       lim = 5'($urandom_range(29, 31));
          2:       lim = FRAME_SAMPLES;
          default: lim = 5'($urandom_range(1, 28));
        endcase
      end else begin
        if ($urandom_range(0, 4) == 0) b = {extreme_nibble(), extreme_nibble()};
        else b = 8'($urandom_range(0, 255));
        lim = 5'($urandom_range(0, 31));
      end
      send_byte(b, ch, lim);
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
src/xad_pkg.sv
src/xad_byte_if.sv
src/xad_sample_if.sv
src/xad_ram.sv
src/xad_predictor.sv
src/xa_adpcm_frame_decoder.sv
tb/sv/xad_decode_checker.sv
tb/sv/xa_adpcm_frame_decoder_test.sv
